>>> design/jse_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper: shared package
// Job descriptor passed from the front part to the back part, escape kinds,
// character constants and small helper functions.
// ----------------------------------------------------------------------------
package jse_pkg;

    // How the body of one code point is written out.
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,   // the character itself
        KIND_SHORT = 2'd1,   // backslash and one letter
        KIND_U16   = 2'd2,   // one \uXXXX escape
        KIND_PAIR  = 2'd3    // two \uXXXX escapes (surrogate pair)
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic         first;
        logic         last;
        logic [3:0]   total;   // characters this word produces, 1 to 14
        logic [20:0]  lit;     // plain char, escape letter or first unit
        logic [9:0]   lo10;    // low ten bits of the second unit
        logic [1:0]   err;
    } t_job;

    localparam logic [20:0] CH_QUOTE  = 21'h000022;
    localparam logic [20:0] CH_BSLASH = 21'h00005C;
    localparam logic [20:0] CH_U      = 21'h000075;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LONE_LOW = 2'd1;
    localparam logic [1:0] ERR_HIGH_END = 2'd2;

    localparam logic [5:0] LOW_SURR_TOP = 6'b110111;

    function automatic logic [3:0] body_len(input t_kind kind);
        logic [3:0] len;
        unique case (kind)
            KIND_PLAIN: len = 4'd1;
            KIND_SHORT: len = 4'd2;
            KIND_U16:   len = 4'd6;
            KIND_PAIR:  len = 4'd12;
            default:    len = 4'd1;
        endcase
        return len;
    endfunction

    // Lowercase hexadecimal digit as a 21-bit character.
    function automatic logic [20:0] hex_char(input logic [3:0] nib);
        logic [20:0] ch;
        if (nib < 4'd10) begin
            ch = 21'h000030 + {17'd0, nib};
        end else begin
            ch = 21'h000057 + {17'd0, nib};
        end
        return ch;
    endfunction

endpackage

>>> design/json_string_escaper_core.sv
// ----------------------------------------------------------------------------
// JSON string escaper core
// Input channel: one code point per word, with first/last-in-string marks;
//   accepted when i_valid is high and o_stall is low.
// Output channel: one escaped character per word, with an end-of-run flag on
//   the last character of each input word and the surrogate error code on
//   every character; taken when o_valid is high and i_stall is low.
// Configuration channel: i_cfg_data is the ascii_mode bit, written when
//   i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high.
// The first character of a word passes through the job queue and then the
//   output register before it is on o_valid.
// The back sequencer writes one character per cycle into the output register
//   while i_stall is low, so a word occupies it for all of the 1 to 14
//   characters it produces; words giving one character flow at one per cycle.
// A two-word job queue decouples the input from the output; o_stall rises
//   when it is full, which happens while the receiver stalls or a long
//   escape is being written out.
// Reset clears the queue, the output valid flag and the surrogate state, and
//   sets ascii_mode to 1.
// ----------------------------------------------------------------------------
module json_string_escaper_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [20:0]  i_code_point,
    input  logic         i_first_in_string,
    input  logic         i_last_in_string,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [20:0]  o_out_char,
    output logic         o_end_of_run,
    output logic [1:0]   o_error_code
);

    logic          r_ascii_mode;
    logic          accept;
    logic          q_full;
    logic          q_nonempty;
    logic          q_pop;
    jse_pkg::t_job front_job;
    jse_pkg::t_job head_job;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign accept      = i_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_ascii_mode <= i_cfg_data;
        end
    end

    jse_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ascii_mode      (r_ascii_mode),
        .i_accept          (accept),
        .i_code_point      (i_code_point),
        .i_first_in_string (i_first_in_string),
        .i_last_in_string  (i_last_in_string),
        .o_job             (front_job)
    );

    jse_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_job      (front_job),
        .i_pop      (q_pop),
        .o_job      (head_job),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_valid  (q_nonempty),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_end_of_run (o_end_of_run),
        .o_error_code (o_error_code)
    );

endmodule

>>> design/jse_front.sv
// ----------------------------------------------------------------------------
// JSON string escaper: front part
// Accepts code points, runs the surrogate check and classifies each one into
// a job descriptor for the back part.
// ----------------------------------------------------------------------------
module jse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ascii_mode,
    input  logic              i_accept,
    input  logic [20:0]       i_code_point,
    input  logic              i_first_in_string,
    input  logic              i_last_in_string,
    output jse_pkg::t_job     o_job
);

    logic        r_skip;
    logic        n_skip;
    logic        skip_eff;
    logic        is_high;
    logic        is_low;
    logic [1:0]  err;
    logic [20:0] reduced;
    logic [15:0] hi_unit;
    logic        is_short;
    logic [20:0] short_ch;
    jse_pkg::t_kind kind;
    logic [20:0] lit;

    assign skip_eff = r_skip & ~i_first_in_string;
    assign is_high  = (i_code_point >= 21'h00D800) && (i_code_point <= 21'h00DBFF);
    assign is_low   = (i_code_point >= 21'h00DC00) && (i_code_point <= 21'h00DFFF);

    always_comb begin
        err    = jse_pkg::ERR_NONE;
        n_skip = 1'b0;
        if (skip_eff) begin
            n_skip = 1'b0;
        end else if (is_high) begin
            if (i_last_in_string) begin
                err = jse_pkg::ERR_HIGH_END;
            end else begin
                n_skip = 1'b1;
            end
        end else if (is_low) begin
            err = jse_pkg::ERR_LONE_LOW;
        end
        if (i_last_in_string) begin
            n_skip = 1'b0;
        end
    end

    always_comb begin
        is_short = 1'b1;
        short_ch = jse_pkg::CH_QUOTE;
        unique case (i_code_point)
            21'h000008: short_ch = 21'h000062;
            21'h000009: short_ch = 21'h000074;
            21'h00000A: short_ch = 21'h00006E;
            21'h00000C: short_ch = 21'h000066;
            21'h00000D: short_ch = 21'h000072;
            21'h000022: short_ch = jse_pkg::CH_QUOTE;
            21'h00002F: short_ch = 21'h00002F;
            21'h00005C: short_ch = jse_pkg::CH_BSLASH;
            default:    is_short = 1'b0;
        endcase
    end

    // Code points beyond the BMP are split into a high and a low unit; the
    // low unit is rebuilt in the back part from its ten payload bits.
    assign reduced = i_code_point - 21'h010000;
    assign hi_unit = {5'd0, reduced[20:10]} + 16'hD800;

    always_comb begin
        if (is_short) begin
            kind = jse_pkg::KIND_SHORT;
            lit  = short_ch;
        end else if (i_code_point <= 21'h00001F) begin
            kind = jse_pkg::KIND_U16;
            lit  = i_code_point;
        end else if (i_ascii_mode && (i_code_point > 21'h00FFFF)) begin
            kind = jse_pkg::KIND_PAIR;
            lit  = {5'd0, hi_unit};
        end else if (i_ascii_mode && (i_code_point > 21'h00007E)) begin
            kind = jse_pkg::KIND_U16;
            lit  = i_code_point;
        end else begin
            kind = jse_pkg::KIND_PLAIN;
            lit  = i_code_point;
        end
    end

    always_comb begin
        o_job.kind  = kind;
        o_job.first = i_first_in_string;
        o_job.last  = i_last_in_string;
        o_job.total = jse_pkg::body_len(kind) + {3'd0, i_first_in_string}
                      + {3'd0, i_last_in_string};
        o_job.lit   = lit;
        o_job.lo10  = reduced[9:0];
        o_job.err   = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
        end else if (i_accept) begin
            r_skip <= n_skip;
        end
    end

endmodule

>>> design/jse_queue.sv
// ----------------------------------------------------------------------------
// JSON string escaper: job queue
// Two-entry queue of job descriptors between the front and the back part.
// ----------------------------------------------------------------------------
module jse_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jse_pkg::t_job     i_job,
    input  logic              i_pop,
    output jse_pkg::t_job     o_job,
    output logic              o_nonempty,
    output logic              o_full
);

    jse_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_job      = r_mem[r_rd];
    assign o_nonempty = (r_count != 2'd0);
    assign o_full     = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> design/jse_back.sv
// ----------------------------------------------------------------------------
// JSON string escaper: back part
// Steps through the characters of the job at the head of the queue, one per
// cycle while i_stall is low, into the output register.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jse_pkg::t_job     i_job,
    input  logic              i_job_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [20:0]       o_out_char,
    output logic              o_end_of_run,
    output logic [1:0]        o_error_code
);

    logic        r_valid;
    logic [20:0] r_char;
    logic        r_end;
    logic [1:0]  r_err;
    logic [3:0]  r_pos;

    logic        advance;
    logic        emit;
    logic        at_end;
    logic [3:0]  bi;
    logic [3:0]  blen;
    logic        sel_lo;
    logic [3:0]  bi_lo;
    logic [2:0]  k;
    logic [15:0] unit;
    logic [20:0] ch;

    assign advance = !r_valid || !i_stall;
    assign emit    = advance && i_job_valid;
    assign at_end  = (r_pos == (i_job.total - 4'd1));
    assign o_pop   = emit && at_end;

    // Position within the escaped body, past the opening quote if present.
    assign bi     = r_pos - {3'd0, i_job.first};
    assign blen   = jse_pkg::body_len(i_job.kind);
    assign sel_lo = (bi >= 4'd6);
    assign bi_lo  = bi - 4'd6;
    assign k      = sel_lo ? bi_lo[2:0] : bi[2:0];
    assign unit   = sel_lo ? {jse_pkg::LOW_SURR_TOP, i_job.lo10} : i_job.lit[15:0];

    always_comb begin
        ch = i_job.lit;
        if (i_job.first && (r_pos == 4'd0)) begin
            ch = jse_pkg::CH_QUOTE;
        end else if (bi == blen) begin
            ch = jse_pkg::CH_QUOTE;
        end else begin
            unique case (i_job.kind) inside
                jse_pkg::KIND_PLAIN: ch = i_job.lit;
                jse_pkg::KIND_SHORT: ch = (bi == 4'd0) ? jse_pkg::CH_BSLASH : i_job.lit;
                jse_pkg::KIND_U16, jse_pkg::KIND_PAIR: begin
                    case (k)
                        3'd0:    ch = jse_pkg::CH_BSLASH;
                        3'd1:    ch = jse_pkg::CH_U;
                        3'd2:    ch = jse_pkg::hex_char(unit[15:12]);
                        3'd3:    ch = jse_pkg::hex_char(unit[11:8]);
                        3'd4:    ch = jse_pkg::hex_char(unit[7:4]);
                        3'd5:    ch = jse_pkg::hex_char(unit[3:0]);
                        default: ch = jse_pkg::CH_BSLASH;
                    endcase
                end
                default: ch = i_job.lit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_end  <= at_end;
            r_err  <= i_job.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
        end else begin
            if (advance) begin
                r_valid <= i_job_valid;
            end
            if (emit) begin
                r_pos <= at_end ? 4'd0 : (r_pos + 4'd1);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_char   = r_char;
    assign o_end_of_run = r_end;
    assign o_error_code = r_err;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// JSON string escaper core: self-checking testbench
// Sends strings of code points through the escaper and checks every escaped
// character, end-of-run flag and error code against an in-bench prediction.
// A directed part covers the short escapes, controls, wide code points and
// surrogate misuse. Random phases then follow, with the sender and the
// receiver idling at different rates and with both ascii_mode settings.
// ----------------------------------------------------------------------------
module testbench;

    // Letters that follow the backslash in the short escapes.
    localparam logic [20:0] LT_B     = 21'h000062;
    localparam logic [20:0] LT_T     = 21'h000074;
    localparam logic [20:0] LT_N     = 21'h00006E;
    localparam logic [20:0] LT_F     = 21'h000066;
    localparam logic [20:0] LT_R     = 21'h000072;
    localparam logic [20:0] LT_SLASH = 21'h00002F;

    localparam logic [20:0] SHORT_SET [8] = '{
        21'h08, 21'h09, 21'h0A, 21'h0C, 21'h0D, 21'h22, 21'h2F, 21'h5C
    };

    typedef struct packed {
        logic [20:0] ch;
        logic        eor;
        logic [1:0]  err;
    } t_esc_char;

    class escape_scoreboard;
        t_esc_char   exp_q[$];
        logic [20:0] run_q[$];
        string       hex_set;
        bit          ascii_mode;
        bit          skip_next;
        int          mismatches;

        function new();
            hex_set    = "0123456789abcdef";
            ascii_mode = 1'b1;
            skip_next  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_ascii(bit m);
            ascii_mode = m;
        endfunction

        function int outstanding();
            return exp_q.size();
        endfunction

        // Only the low 16 bits of a unit are shown.
        function void put_unit(int v);
            run_q.push_back(jse_pkg::CH_BSLASH);
            run_q.push_back(jse_pkg::CH_U);
            for (int s = 12; s >= 0; s -= 4) begin
                run_q.push_back({13'd0, hex_set[(v >> s) & 15]});
            end
        endfunction

        function void note_word(logic [20:0] cp, bit first, bit last);
            logic [1:0]  err;
            logic [20:0] letter;
            int          red;
            err = jse_pkg::ERR_NONE;
            if (first) skip_next = 1'b0;
            if (skip_next) begin
                skip_next = 1'b0;
            end else if (cp >= 21'hD800 && cp <= 21'hDBFF) begin
                if (last) err = jse_pkg::ERR_HIGH_END;
                else skip_next = 1'b1;
            end else if (cp >= 21'hDC00 && cp <= 21'hDFFF) begin
                err = jse_pkg::ERR_LONE_LOW;
            end
            if (last) skip_next = 1'b0;

            run_q.delete();
            if (first) run_q.push_back(jse_pkg::CH_QUOTE);
            case (cp)
                21'h08:  letter = LT_B;
                21'h09:  letter = LT_T;
                21'h0A:  letter = LT_N;
                21'h0C:  letter = LT_F;
                21'h0D:  letter = LT_R;
                21'h22:  letter = jse_pkg::CH_QUOTE;
                21'h2F:  letter = LT_SLASH;
                21'h5C:  letter = jse_pkg::CH_BSLASH;
                default: letter = '0;
            endcase
            if (letter != '0) begin
                run_q.push_back(jse_pkg::CH_BSLASH);
                run_q.push_back(letter);
            end else if (cp <= 21'h1F) begin
                put_unit(int'(cp));
            end else if (ascii_mode && cp > 21'hFFFF) begin
                red = int'(cp) - 'h10000;
                put_unit((red >> 10) + 'hD800);
                put_unit((red & 'h3FF) + 'hDC00);
            end else if (ascii_mode && cp > 21'h7E) begin
                put_unit(int'(cp));
            end else begin
                run_q.push_back(cp);
            end
            if (last) run_q.push_back(jse_pkg::CH_QUOTE);

            foreach (run_q[i]) begin
                exp_q.push_back('{run_q[i], (i == run_q.size() - 1), err});
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_char(logic [20:0] ch, logic eor, logic [1:0] err);
            t_esc_char e;
            if (exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h eor %b err %0d", ch, eor, err));
                return;
            end
            e = exp_q.pop_front();
            if (ch !== e.ch || eor !== e.eor || err !== e.err) begin
                report_mismatch($sformatf("char %h/%h eor %b/%b err %0d/%0d (got/exp)",
                                          ch, e.ch, eor, e.eor, err, e.err));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [20:0] i_code_point = '0;
    logic        i_first_in_string = 1'b0;
    logic        i_last_in_string = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [20:0] o_out_char;
    logic        o_end_of_run;
    logic [1:0]  o_error_code;

    logic        hold_rx = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          sent;
    escape_scoreboard sb;

    json_string_escaper_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_code_point      (i_code_point),
        .i_first_in_string (i_first_in_string),
        .i_last_in_string  (i_last_in_string),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_char        (o_out_char),
        .o_end_of_run      (o_end_of_run),
        .o_error_code      (o_error_code)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= hold_rx || ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char(o_out_char, o_end_of_run, o_error_code);
        end
    end

    initial begin
        #(12 * 500000);
        $display("DONE: errors detected");
        $finish;
    end

    task send_word(logic [20:0] cp, bit first, bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_code_point      <= cp;
        i_first_in_string <= first;
        i_last_in_string  <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(cp, first, last);
    endtask

    task write_ascii_mode(bit m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_ascii(m);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits for every expected character, then lets the pipeline settle.
    task drain();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_receiver(int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx <= 1'b0;
    endtask

    function automatic logic [20:0] random_code_point();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 21'($urandom_range('h20, 'h7E));
        if (pick < 50) return SHORT_SET[$urandom_range(0, 7)];
        if (pick < 55) return 21'($urandom_range(0, 'h1F));
        if (pick < 70) return 21'($urandom_range('h7F, 'hFFFF));
        if (pick < 80) return 21'($urandom_range('h10000, 'h10FFFF));
        if (pick < 85) return 21'($urandom_range('h110000, 'h1FFFFF));
        if (pick < 90) return 21'($urandom_range('hDC00, 'hDFFF));
        return 21'($urandom_range('hD800, 'hDBFF));
    endfunction

    // A string of random code points; a high surrogate is usually followed by a low one.
    task send_random_string();
        int          len;
        logic [20:0] cp;
        bit          pair;
        len  = $urandom_range(1, 6);
        pair = 1'b0;
        for (int i = 0; i < len; i++) begin
            if (pair) cp = 21'($urandom_range('hDC00, 'hDFFF));
            else cp = random_code_point();
            pair = (cp >= 21'hD800 && cp <= 21'hDBFF && $urandom_range(0, 4) != 0);
            send_word(cp, i == 0, i == len - 1);
            sent++;
        end
    endtask

    task run_phase(int target, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        sent          = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(random_code_point(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_random_string();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_ascii_mode(1'b1);

        // Directed words: a one-character string, then every escape class.
        send_word(21'h41, 1'b1, 1'b1);
        send_word(21'h00, 1'b1, 1'b0);
        send_word(21'h08, 1'b0, 1'b0);
        send_word(21'h09, 1'b0, 1'b0);
        send_word(21'h0A, 1'b0, 1'b0);
        send_word(21'h0C, 1'b0, 1'b0);
        send_word(21'h0D, 1'b0, 1'b0);
        send_word(21'h1F, 1'b0, 1'b0);
        send_word(21'h22, 1'b0, 1'b0);
        send_word(21'h2F, 1'b0, 1'b0);
        send_word(21'h5C, 1'b0, 1'b0);
        send_word(21'h7E, 1'b0, 1'b0);
        send_word(21'h7F, 1'b0, 1'b0);
        send_word(21'hFFFF, 1'b0, 1'b0);
        send_word(21'h10000, 1'b0, 1'b0);
        send_word(21'h10FFFF, 1'b0, 1'b0);
        send_word(21'h1FFFFF, 1'b0, 1'b1);
        // A proper pair, then a lone low one and a high one ending the string.
        send_word(21'hD83D, 1'b1, 1'b0);
        send_word(21'hDE00, 1'b0, 1'b1);
        send_word(21'hDC00, 1'b1, 1'b0);
        send_word(21'hDBFF, 1'b0, 1'b0);
        send_word(21'hD800, 1'b0, 1'b0);
        send_word(21'hDFFF, 1'b0, 1'b0);
        send_word(21'hDBFF, 1'b0, 1'b1);
        // A new string start clears a pending high surrogate.
        send_word(21'hD800, 1'b1, 1'b0);
        send_word(21'hDC00, 1'b1, 1'b1);
        // A word with neither mark gets no quotes.
        send_word(21'h20, 1'b0, 1'b0);
        drain();

        // The receiver holds off long enough for the input to back up.
        fork
            hold_receiver(300);
        join_none
        run_phase(38, 0, 0);
        drain();

        write_ascii_mode(1'b0);
        run_phase(38, 82, 0);
        drain();

        write_ascii_mode(1'b1);
        run_phase(38, 0, 82);
        drain();

        write_ascii_mode(1'b0);
        run_phase(38, 24, 24);
        drain();
        repeat (16) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
